### design/rgba_to_yuv420_semiplanar_top_defines.svh
// Assertion macros shared by the RGBA to YUV 4:2:0 converter RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef RGBA_TO_YUV420_SEMIPLANAR_TOP_DEFINES_SVH
`define RGBA_TO_YUV420_SEMIPLANAR_TOP_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define R2Y_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define R2Y_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rgb2yuv_pkg.sv
// Shared types, sizes and coefficients of the RGBA to YUV 4:2:0 converter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rgb2yuv_pkg;

    // Frame size limits and counter widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_SIZE   = 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WSIZE_W    = COL_W + 1;
    localparam int HSIZE_W    = ROW_W + 1;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Line store: one entry holds a pair of adjacent columns.
    localparam int PAIR_DEPTH = MAX_WIDTH / 2;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

    // Fixed-point formats.
    localparam int PIX_W  = 8;
    localparam int FRAC_W = 16;
    localparam int CH_W   = PIX_W + FRAC_W;
    localparam int SUM_W  = CH_W + 2;
    localparam int ACC_W  = 27;
    localparam int COEF_W = 18;

    localparam logic signed [ACC_W-1:0] CLAMP_TOP     = ACC_W'(255 * (1 << FRAC_W));
    localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = ACC_W'(128 * (1 << FRAC_W));

    // BT.601 weights with 16 fractional bits.
    localparam logic signed [COEF_W-1:0] COEF_Y_R  = COEF_W'(19589);
    localparam logic signed [COEF_W-1:0] COEF_Y_G  = COEF_W'(38443);
    localparam logic signed [COEF_W-1:0] COEF_Y_B  = COEF_W'(7504);
    localparam logic signed [COEF_W-1:0] COEF_CB_R = -COEF_W'(11062);
    localparam logic signed [COEF_W-1:0] COEF_CB_G = -COEF_W'(21706);
    localparam logic signed [COEF_W-1:0] COEF_CB_B = COEF_W'(32768);
    localparam logic signed [COEF_W-1:0] COEF_CR_R = COEF_W'(32768);
    localparam logic signed [COEF_W-1:0] COEF_CR_G = -COEF_W'(27420);
    localparam logic signed [COEF_W-1:0] COEF_CR_B = -COEF_W'(5348);

    // Clamped chroma of one pixel.
    typedef struct packed {
        logic [CH_W-1:0] cb;
        logic [CH_W-1:0] cr;
    } chroma_t;

    // Line store entry: odd column in the upper half, even column below.
    typedef struct packed {
        chroma_t odd_px;
        chroma_t even_px;
    } pair_t;

    // Position of the pixel being accepted.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             odd_row;
        logic             frame_end;
    } pos_t;

endpackage

`default_nettype wire

### design/rgb2yuv_pos.sv
// Frame size registers and the column and row counters of the converter.
// Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_pos (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rgb2yuv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgb2yuv_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                               pix_accept,
    output rgb2yuv_pkg::pos_t                       pos
);

    logic [rgb2yuv_pkg::WSIZE_W-1:0] width_reg, width_next;
    logic [rgb2yuv_pkg::HSIZE_W-1:0] height_reg, height_next;
    logic [rgb2yuv_pkg::COL_W-1:0]   col_reg, col_next;
    logic [rgb2yuv_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                            last_col;
    logic                            last_row;

    // Sizes outside the legal range are pulled to the nearest bound.
    function automatic int bound_size(input logic [rgb2yuv_pkg::CFG_W-1:0] v, input int top);
        int val;
        val = int'(v);
        if (val < rgb2yuv_pkg::MIN_SIZE) begin
            return rgb2yuv_pkg::MIN_SIZE;
        end
        if (val > top) begin
            return top;
        end
        return val;
    endfunction

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rgb2yuv_pkg::REG_FRAME_WIDTH: begin
                    width_next = rgb2yuv_pkg::WSIZE_W'(
                        bound_size(cfg_data, rgb2yuv_pkg::MAX_WIDTH));
                end
                rgb2yuv_pkg::REG_FRAME_HEIGHT: begin
                    height_next = rgb2yuv_pkg::HSIZE_W'(
                        bound_size(cfg_data, rgb2yuv_pkg::MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // A counter at or past its last position wraps after this pixel.
    assign last_col = ({1'b0, col_reg} + 1'b1) >= width_reg;
    assign last_row = ({1'b0, row_reg} + 1'b1) >= height_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rgb2yuv_pkg::WSIZE_W'(rgb2yuv_pkg::WIDTH_RESET);
            height_reg <= rgb2yuv_pkg::HSIZE_W'(rgb2yuv_pkg::HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Position of the pixel that is accepted in this cycle.
    assign pos.col       = col_reg;
    assign pos.odd_row   = row_reg[0];
    assign pos.frame_end = last_col && last_row;

endmodule

`default_nettype wire

### design/rgb2yuv_line_mem.sv
// Line store of the converter: clamped chroma of the previous even row,
// two columns per entry, one write and one registered read port.
// Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_line_mem (
    input  wire logic                              aclk,
    input  wire logic                              wr_en,
    input  wire logic [rgb2yuv_pkg::PAIR_AW-1:0]   wr_addr,
    input  wire rgb2yuv_pkg::pair_t                wr_data,
    input  wire logic                              rd_en,
    input  wire logic [rgb2yuv_pkg::PAIR_AW-1:0]   rd_addr,
    output rgb2yuv_pkg::pair_t                     rd_data
);

    rgb2yuv_pkg::pair_t mem [rgb2yuv_pkg::PAIR_DEPTH];
    rgb2yuv_pkg::pair_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/rgb2yuv_csc.sv
// Color matrix of the converter: luma byte and clamped Cb and Cr of one pixel.
// Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_csc (
    input  wire logic [rgb2yuv_pkg::PIX_W-1:0] red,
    input  wire logic [rgb2yuv_pkg::PIX_W-1:0] green,
    input  wire logic [rgb2yuv_pkg::PIX_W-1:0] blue,
    output logic [rgb2yuv_pkg::PIX_W-1:0]      luma,
    output rgb2yuv_pkg::chroma_t               chroma
);

    logic signed [rgb2yuv_pkg::ACC_W-1:0] r_s, g_s, b_s;
    logic signed [rgb2yuv_pkg::ACC_W-1:0] y_sum, cb_sum, cr_sum;
    logic [rgb2yuv_pkg::CH_W-1:0]         y_clamp;

    // Clamp a weighted sum to 0 .. 255.0 in 16-bit fraction.
    function automatic logic [rgb2yuv_pkg::CH_W-1:0] clamp_fix(
        input logic signed [rgb2yuv_pkg::ACC_W-1:0] v
    );
        if (v < 0) begin
            return '0;
        end
        if (v > rgb2yuv_pkg::CLAMP_TOP) begin
            return rgb2yuv_pkg::CH_W'(rgb2yuv_pkg::CLAMP_TOP);
        end
        return v[rgb2yuv_pkg::CH_W-1:0];
    endfunction

    assign r_s = rgb2yuv_pkg::ACC_W'(red);
    assign g_s = rgb2yuv_pkg::ACC_W'(green);
    assign b_s = rgb2yuv_pkg::ACC_W'(blue);

    // Weighted sums with constant coefficients.
    assign y_sum  = r_s * rgb2yuv_pkg::COEF_Y_R + g_s * rgb2yuv_pkg::COEF_Y_G
                  + b_s * rgb2yuv_pkg::COEF_Y_B;
    assign cb_sum = r_s * rgb2yuv_pkg::COEF_CB_R + g_s * rgb2yuv_pkg::COEF_CB_G
                  + b_s * rgb2yuv_pkg::COEF_CB_B + rgb2yuv_pkg::CHROMA_OFFSET;
    assign cr_sum = r_s * rgb2yuv_pkg::COEF_CR_R + g_s * rgb2yuv_pkg::COEF_CR_G
                  + b_s * rgb2yuv_pkg::COEF_CR_B + rgb2yuv_pkg::CHROMA_OFFSET;

    // Luma keeps the integer part; chroma keeps its fraction for averaging.
    assign y_clamp   = clamp_fix(y_sum);
    assign luma      = y_clamp[rgb2yuv_pkg::CH_W-1 -: rgb2yuv_pkg::PIX_W];
    assign chroma.cb = clamp_fix(cb_sum);
    assign chroma.cr = clamp_fix(cr_sum);

endmodule

`default_nettype wire

### design/rgba_to_yuv420_semiplanar_top.sv
// RGBA to YUV 4:2:0 semi-planar converter with BT.601 weights.
//
// Pixels enter on the s_ channel in raster order, one beat per pixel, and
// leave on the m_ channel, one beat per pixel, in the same order. Every beat
// carries the pixel's luma; at an odd column of an odd row it also carries the
// mean Cb and Cr of the 2x2 block ending at that pixel, flagged by m_tuser.
// m_tlast marks the last pixel of the frame. The frame size is written on the
// cfg channel (index 0 width, index 1 height); the user must do so only while
// no pixel is in flight, as the block does not enforce it. Throughput is one
// pixel per clock while m_tready is high. Stages: input register, color matrix
// into the chroma register, block average into the output register. The line
// store is read in the cycle a pixel is accepted and written when an
// odd-column pixel of an even row leaves the input register. Reset empties
// the pipeline, returns the counters to the first pixel and the size to
// 640x480; the line store is not cleared, since an odd row only reads what
// the even row before it wrote. When the receiver stalls, the stages fill
// behind the output register and s_tready falls once all three hold a pixel.
// Depends on rgb2yuv_pkg, rgb2yuv_pos, rgb2yuv_line_mem, rgb2yuv_csc.
`default_nettype none

`include "rgba_to_yuv420_semiplanar_top_defines.svh"

module rgba_to_yuv420_semiplanar_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rgb2yuv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgb2yuv_pkg::CFG_W-1:0]      cfg_data,
    // Pixel input.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [23:0]                        s_tdata,  // red, green, blue
    // Converted output.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [23:0]                             m_tdata,  // luma, cb_mean, cr_mean
    output logic                                    m_tuser,  // chroma_valid
    output logic                                    m_tlast   // frame_end
);

    localparam int PW = rgb2yuv_pkg::PIX_W;

    logic adv1, adv2, adv3, pix_accept, xfer12;
    logic v1_reg, v2_reg, v3_reg;

    rgb2yuv_pkg::pos_t    cur_pos;
    rgb2yuv_pkg::pair_t   up_pair;
    rgb2yuv_pkg::pair_t   wr_pair;
    logic                 line_we;

    // Input register stage.
    logic [PW-1:0]        red_reg, green_reg, blue_reg;
    rgb2yuv_pkg::pos_t    s1_pos_reg;

    // Color matrix outputs.
    logic [PW-1:0]        luma_c;
    rgb2yuv_pkg::chroma_t here_c;
    rgb2yuv_pkg::chroma_t left_reg;
    logic [rgb2yuv_pkg::CH_W:0] up_cb_c, up_cr_c;

    // Chroma register stage.
    logic [PW-1:0]              s2_luma_reg;
    rgb2yuv_pkg::chroma_t       s2_here_reg;
    rgb2yuv_pkg::chroma_t       s2_left_reg;
    logic [rgb2yuv_pkg::CH_W:0] s2_up_cb_reg, s2_up_cr_reg;
    logic                       s2_cvalid_reg;
    logic                       s2_fend_reg;

    // Block average.
    logic [rgb2yuv_pkg::SUM_W-1:0] cb_sum, cr_sum;
    logic [PW-1:0]                 cb_mean, cr_mean;

    // Output register stage.
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    // Each stage loads when it is empty or its content moves on.
    assign adv3       = !v3_reg || m_tready;
    assign adv2       = !v2_reg || adv3;
    assign adv1       = !v1_reg || adv2;
    assign s_tready   = adv1;
    assign pix_accept = s_tvalid && s_tready;
    assign xfer12     = v1_reg && adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= pix_accept;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    rgb2yuv_pos u_pos (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .pos        (cur_pos)
    );

    // The pair above this column is fetched as the pixel is taken in.
    rgb2yuv_line_mem u_line_mem (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (s1_pos_reg.col[rgb2yuv_pkg::COL_W-1:1]),
        .wr_data (wr_pair),
        .rd_en   (pix_accept),
        .rd_addr (cur_pos.col[rgb2yuv_pkg::COL_W-1:1]),
        .rd_data (up_pair)
    );

    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            red_reg    <= s_tdata[PW-1:0];
            green_reg  <= s_tdata[2*PW-1:PW];
            blue_reg   <= s_tdata[3*PW-1:2*PW];
            s1_pos_reg <= cur_pos;
        end
    end

    rgb2yuv_csc u_csc (
        .red    (red_reg),
        .green  (green_reg),
        .blue   (blue_reg),
        .luma   (luma_c),
        .chroma (here_c)
    );

    // Even rows store each column pair once its odd pixel is known.
    assign line_we         = xfer12 && !s1_pos_reg.odd_row && s1_pos_reg.col[0];
    assign wr_pair.odd_px  = here_c;
    assign wr_pair.even_px = left_reg;

    // Upper half of the 2x2 block.
    assign up_cb_c = {1'b0, up_pair.odd_px.cb} + {1'b0, up_pair.even_px.cb};
    assign up_cr_c = {1'b0, up_pair.odd_px.cr} + {1'b0, up_pair.even_px.cr};

    // Chroma of the previous pixel in raster order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (xfer12) begin
            left_reg <= here_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer12) begin
            s2_luma_reg   <= luma_c;
            s2_here_reg   <= here_c;
            s2_left_reg   <= left_reg;
            s2_up_cb_reg  <= up_cb_c;
            s2_up_cr_reg  <= up_cr_c;
            s2_cvalid_reg <= s1_pos_reg.odd_row && s1_pos_reg.col[0];
            s2_fend_reg   <= s1_pos_reg.frame_end;
        end
    end

    // Truncated mean of four clamped values.
    assign cb_sum = rgb2yuv_pkg::SUM_W'(s2_here_reg.cb) + rgb2yuv_pkg::SUM_W'(s2_left_reg.cb)
                  + rgb2yuv_pkg::SUM_W'(s2_up_cb_reg);
    assign cr_sum = rgb2yuv_pkg::SUM_W'(s2_here_reg.cr) + rgb2yuv_pkg::SUM_W'(s2_left_reg.cr)
                  + rgb2yuv_pkg::SUM_W'(s2_up_cr_reg);
    assign cb_mean = s2_cvalid_reg ? cb_sum[rgb2yuv_pkg::SUM_W-1 -: PW] : '0;
    assign cr_mean = s2_cvalid_reg ? cr_sum[rgb2yuv_pkg::SUM_W-1 -: PW] : '0;

    always_ff @(posedge aclk) begin
        if (adv3 && v2_reg) begin
            m_tdata_reg <= {cr_mean, cb_mean, s2_luma_reg};
            m_tuser_reg <= s2_cvalid_reg;
            m_tlast_reg <= s2_fend_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // A beat without chroma carries zero means.
    `R2Y_ASSERT_NOW(a_zero_chroma, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[23:8] == 16'h0, "chroma means not zero on a luma-only beat")

    // The input stalls only when every stage holds a pixel and the output waits.
    `R2Y_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_tready,
        v1_reg && v2_reg && m_tvalid && !m_tready, "input stalled with a free stage")

    // A new output beat always comes from a filled chroma stage.
    `R2Y_ASSERT_NOW(a_out_source, aclk, aresetn, $rose(m_tvalid),
        $past(v2_reg), "output became valid without a pixel behind it")

endmodule

`default_nettype wire
